// ===== hdl/uv_sphere_mesh_generator_unit_assert.svh =====
// Assertion macros shared by the UV sphere generator RTL.
// Depends on nothing; files that check their logic include it.
`ifndef UV_SPHERE_MESH_GENERATOR_UNIT_ASSERT_SVH
`define UV_SPHERE_MESH_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication under a synchronous reset
`define UVS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uvs same-cycle check failed");

// Next-cycle implication under a synchronous reset
`define UVS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uvs next-cycle check failed");

`endif

// ===== hdl/uvs_pkg.sv =====
// Shared types, constants and pipeline layout of the UV sphere generator.
// Depends on nothing; every module uses it by scoped names.
package uvs_pkg;

  // Field and register widths
  localparam int CNT_W   = 9;
  localparam int IDX_W   = 9;
  localparam int RAD_W   = 16;
  localparam int POS_W   = 17;
  localparam int NRM_W   = 16;
  localparam int TEX_W   = 17;
  localparam int CRN_W   = 17;
  localparam int CFG_W   = 16;
  localparam int CFGI_W  = 2;

  // Defaults of the top-level parameters
  localparam int MAX_SECTORS_DEF = 256;
  localparam int MAX_STACKS_DEF  = 256;

  // Register indexes
  localparam logic [CFGI_W-1:0] CFG_SECTOR_COUNT  = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_STACK_COUNT   = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_SPHERE_RADIUS = 2'd2;

  // Register reset values
  localparam logic [CNT_W-1:0] SECTOR_RST = 9'd36;
  localparam logic [CNT_W-1:0] STACK_RST  = 9'd18;
  localparam logic [RAD_W-1:0] RADIUS_RST = 16'd256;

  // Divider: index << 17 over a count, quotient of 18 bits
  localparam int QUO_W      = 18;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = 7;
  localparam int DIV_NUM_W  = DIV_STEPS * DIV_STAGES;

  // Sine evaluator
  localparam int SIN_STAGES = 4;
  localparam int MAG_W      = 15;
  localparam logic [15:0]      PHASE_QUARTER = 16'd16384;
  localparam logic [MAG_W-1:0] ONE_Q14       = 15'd16384;
  localparam logic [10:0]      SIN_C1        = 11'd1160;
  localparam logic [13:0]      SIN_C2        = 14'd10512;
  localparam logic [14:0]      SIN_C3        = 15'd25736;

  // Pipeline layout: input, divider, sine, two scale stages
  localparam int SCL_STAGES = 2;
  localparam int SIN_FIRST  = DIV_STAGES + 1;
  localparam int SCL_FIRST  = SIN_FIRST + SIN_STAGES;
  localparam int NUM_STAGES = SCL_FIRST + SCL_STAGES;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } sine_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [NRM_W-1:0] norm_x;
    logic signed [NRM_W-1:0] norm_y;
    logic signed [NRM_W-1:0] norm_z;
  } vert_t;

  typedef struct packed {
    logic             op;
    logic [1:0]       cnt;
    logic             has_a;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [CRN_W-1:0] k1;
    logic [TEX_W-1:0] u;
    logic [TEX_W-1:0] v;
  } side_t;

endpackage

// ===== hdl/uv_sphere_mesh_generator_unit.sv =====
// UV sphere mesh generator, top level: config registers, pipeline control, output.
// Depends on uvs_pkg, uvs_div, uvs_sine, uvs_scale and the assertion header.
//
// Usage: write sector_count, stack_count and sphere_radius on the cfg port
// (cfg_write, cfg_index, cfg_data) while the block is idle. Send one grid cell
// per word on in_valid/in_ready: operation 0 asks for the vertex at (stack,
// sector), operation 1 for the triangles of that cell. Results leave on
// out_valid/out_ready, with last set on the final word of each cell.
// A cell passes one input stage, seven divider stages (four quotient bits
// each), four sine stages and two scaling stages, fourteen registers in all,
// before its first result word is presented. One cell enters every cycle
// while in_ready is high; a cell with two triangles holds the output stage
// until both words are taken, so the output port at one word per cycle sets
// the sustained rate. Cells with no result leave without a word.
// Reset loads the default counts and radius and empties the pipeline.
// When the receiver stalls, words hold in place, empty stages close up, and
// in_ready falls only once every stage holds a cell.
module uv_sphere_mesh_generator_unit #(
  parameter int MAX_SECTORS = uvs_pkg::MAX_SECTORS_DEF,
  parameter int MAX_STACKS  = uvs_pkg::MAX_STACKS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [uvs_pkg::CFGI_W-1:0]         cfg_index,
  input  logic [uvs_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               operation,
  input  logic [uvs_pkg::IDX_W-1:0]          stack_index,
  input  logic [uvs_pkg::IDX_W-1:0]          sector_index,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [uvs_pkg::POS_W-1:0]   pos_x,
  output logic signed [uvs_pkg::POS_W-1:0]   pos_y,
  output logic signed [uvs_pkg::POS_W-1:0]   pos_z,
  output logic signed [uvs_pkg::NRM_W-1:0]   norm_x,
  output logic signed [uvs_pkg::NRM_W-1:0]   norm_y,
  output logic signed [uvs_pkg::NRM_W-1:0]   norm_z,
  output logic [uvs_pkg::TEX_W-1:0]          tex_u,
  output logic [uvs_pkg::TEX_W-1:0]          tex_v,
  output logic [uvs_pkg::CRN_W-1:0]          corner_a,
  output logic [uvs_pkg::CRN_W-1:0]          corner_b,
  output logic [uvs_pkg::CRN_W-1:0]          corner_c,
  output logic                               last
);

  `include "uv_sphere_mesh_generator_unit_assert.svh"

  localparam int LAST = uvs_pkg::NUM_STAGES - 1;
  localparam int CNT_LIM = (1 << uvs_pkg::CNT_W) - 1;
  localparam logic [uvs_pkg::CNT_W-1:0] S_MAX =
    uvs_pkg::CNT_W'((MAX_SECTORS > CNT_LIM) ? CNT_LIM : MAX_SECTORS);
  localparam logic [uvs_pkg::CNT_W-1:0] T_MAX =
    uvs_pkg::CNT_W'((MAX_STACKS > CNT_LIM) ? CNT_LIM : MAX_STACKS);

  logic [uvs_pkg::CNT_W-1:0] sector_count, stack_count, ns, nt;
  logic [uvs_pkg::RAD_W-1:0] sphere_radius;
  logic [uvs_pkg::NUM_STAGES-1:0] vld, en;
  uvs_pkg::side_t side [uvs_pkg::NUM_STAGES];
  uvs_pkg::side_t side_in;
  uvs_pkg::side_t side_k1, side_uv;
  logic          pend;
  logic          done;
  logic          vert_ok, cell_ok, has_b;
  logic [18:0]   k1_full;
  logic [uvs_pkg::QUO_W-1:0] qj_w, qi_w;
  logic [uvs_pkg::QUO_W-1:0] qj, qi;
  logic [uvs_pkg::TEX_W-1:0] v_half;
  logic [15:0]   pj, ps;
  uvs_pkg::sine_t si, ci, sj, cj;
  uvs_pkg::vert_t vert;
  logic          use_b, is_vert;
  logic [uvs_pkg::CRN_W-1:0] k1, k1p, k2, k2p;

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sector_count  <= uvs_pkg::SECTOR_RST;
      stack_count   <= uvs_pkg::STACK_RST;
      sphere_radius <= uvs_pkg::RADIUS_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        uvs_pkg::CFG_SECTOR_COUNT:  sector_count  <= cfg_data[uvs_pkg::CNT_W-1:0];
        uvs_pkg::CFG_STACK_COUNT:   stack_count   <= cfg_data[uvs_pkg::CNT_W-1:0];
        uvs_pkg::CFG_SPHERE_RADIUS: sphere_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp counts into one to the maximum
  always_comb begin
    ns = sector_count;
    if (sector_count == '0) ns = uvs_pkg::CNT_W'(1);
    else if (sector_count > S_MAX) ns = S_MAX;
    nt = stack_count;
    if (stack_count == '0) nt = uvs_pkg::CNT_W'(1);
    else if (stack_count > T_MAX) nt = T_MAX;
  end

  // Classify the incoming word and count its results
  always_comb begin
    vert_ok = (stack_index <= nt) && (sector_index <= ns);
    cell_ok = (stack_index < nt) && (sector_index < ns);
    has_b   = stack_index != (nt - uvs_pkg::CNT_W'(1));
    side_in = '0;
    side_in.op    = operation;
    side_in.i     = stack_index;
    side_in.j     = sector_index;
    side_in.has_a = stack_index != '0;
    if (operation) begin
      side_in.cnt = cell_ok ? ({1'b0, side_in.has_a} + {1'b0, has_b}) : 2'd0;
    end else begin
      side_in.cnt = vert_ok ? 2'd1 : 2'd0;
    end
  end

  // Let a stage move when it is empty or its successor moves
  assign done = (side[LAST].cnt == 2'd0) ||
                (out_ready && ((side[LAST].cnt == 2'd1) || pend));
  always_comb begin
    en[LAST] = !vld[LAST] || done;
    for (int k = LAST - 1; k >= 0; k--) en[k] = !vld[k] || en[k+1];
  end
  assign in_ready = en[0];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < uvs_pkg::NUM_STAGES; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Carry side data; fill the base index and texture coordinates on the way
  assign k1_full = 19'(side[0].i) * 19'(ns) + 19'(side[0].j);
  assign qj      = qj_w;
  assign qi      = qi_w;
  assign v_half  = uvs_pkg::TEX_W'(qi >> 1);
  assign pj      = 16'((qj + uvs_pkg::QUO_W'(1)) >> 1);
  assign ps      = 16'((v_half + uvs_pkg::TEX_W'(1)) >> 1);

  always_comb begin
    side_k1    = side[0];
    side_k1.k1 = k1_full[uvs_pkg::CRN_W-1:0] + uvs_pkg::CRN_W'(side[0].i);
    side_uv    = side[uvs_pkg::SIN_FIRST-1];
    side_uv.u  = uvs_pkg::TEX_W'(qj >> 1);
    side_uv.v  = v_half;
  end

  always_ff @(posedge clk) begin
    if (en[0]) side[0] <= side_in;
    for (int k = 1; k < uvs_pkg::NUM_STAGES; k++) begin
      if (en[k]) begin
        if (k == 1) side[k] <= side_k1;
        else if (k == uvs_pkg::SIN_FIRST) side[k] <= side_uv;
        else side[k] <= side[k-1];
      end
    end
  end

  uvs_div u_div_j (
    .clk   (clk),
    .en    (en[uvs_pkg::DIV_STAGES:1]),
    .index (side[0].j),
    .count (ns),
    .quo   (qj_w)
  );

  uvs_div u_div_i (
    .clk   (clk),
    .en    (en[uvs_pkg::DIV_STAGES:1]),
    .index (side[0].i),
    .count (nt),
    .quo   (qi_w)
  );

  uvs_sine u_sin_i (
    .clk    (clk),
    .en     (en[uvs_pkg::SCL_FIRST-1:uvs_pkg::SIN_FIRST]),
    .phase  (ps),
    .result (si)
  );

  uvs_sine u_cos_i (
    .clk    (clk),
    .en     (en[uvs_pkg::SCL_FIRST-1:uvs_pkg::SIN_FIRST]),
    .phase  (ps + uvs_pkg::PHASE_QUARTER),
    .result (ci)
  );

  uvs_sine u_sin_j (
    .clk    (clk),
    .en     (en[uvs_pkg::SCL_FIRST-1:uvs_pkg::SIN_FIRST]),
    .phase  (pj),
    .result (sj)
  );

  uvs_sine u_cos_j (
    .clk    (clk),
    .en     (en[uvs_pkg::SCL_FIRST-1:uvs_pkg::SIN_FIRST]),
    .phase  (pj + uvs_pkg::PHASE_QUARTER),
    .result (cj)
  );

  uvs_scale u_scale (
    .clk    (clk),
    .en     (en[LAST:uvs_pkg::SCL_FIRST]),
    .radius (sphere_radius),
    .si     (si),
    .ci     (ci),
    .sj     (sj),
    .cj     (cj),
    .vert   (vert)
  );

  // Track the second triangle of a two-triangle cell
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (out_valid && out_ready) begin
      pend <= (side[LAST].cnt == 2'd2) && !pend;
    end
  end

  // Drive the output word
  always_comb begin
    is_vert  = !side[LAST].op;
    use_b    = pend || !side[LAST].has_a;
    k1       = side[LAST].k1;
    k1p      = k1 + uvs_pkg::CRN_W'(1);
    k2       = k1 + uvs_pkg::CRN_W'(ns) + uvs_pkg::CRN_W'(1);
    k2p      = k2 + uvs_pkg::CRN_W'(1);
    out_valid = vld[LAST] && (side[LAST].cnt != 2'd0);
    last     = (side[LAST].cnt == 2'd1) || pend;
    pos_x    = is_vert ? vert.pos_x : '0;
    pos_y    = is_vert ? vert.pos_y : '0;
    pos_z    = is_vert ? vert.pos_z : '0;
    norm_x   = is_vert ? vert.norm_x : '0;
    norm_y   = is_vert ? vert.norm_y : '0;
    norm_z   = is_vert ? vert.norm_z : '0;
    tex_u    = is_vert ? side[LAST].u : '0;
    tex_v    = is_vert ? side[LAST].v : '0;
    corner_a = is_vert ? '0 : (use_b ? k1p : k1);
    corner_b = is_vert ? '0 : k2;
    corner_c = is_vert ? '0 : (use_b ? k2p : k1p);
  end

  // Pipeline control checks
  `UVS_ASSERT_IMP(a_empty_ready, clk, rst, !vld[LAST], in_ready)
  `UVS_ASSERT_IMP(a_out_has_cell, clk, rst, out_valid, vld[LAST])
  `UVS_ASSERT_IMP(a_pend_two, clk, rst, pend, vld[LAST] && (side[LAST].cnt == 2'd2))
  `UVS_ASSERT_NXT(a_second_word, clk, rst, out_valid && out_ready && !last, out_valid && last)

endmodule

// ===== hdl/uvs_div.sv =====
// Pipelined restoring divider: floor((index << 17) / count), 4 steps a stage.
// Depends on uvs_pkg; stage enables come from the top-level pipeline control.
module uvs_div (
  input  logic                               clk,
  input  logic [uvs_pkg::DIV_STAGES-1:0]     en,
  input  logic [uvs_pkg::IDX_W-1:0]          index,
  input  logic [uvs_pkg::CNT_W-1:0]          count,
  output logic [uvs_pkg::QUO_W-1:0]          quo
);

  logic [uvs_pkg::CNT_W-1:0]     rem_r [uvs_pkg::DIV_STAGES];
  logic [uvs_pkg::DIV_NUM_W-1:0] num_r [uvs_pkg::DIV_STAGES];
  logic [uvs_pkg::QUO_W-1:0]     quo_r [uvs_pkg::DIV_STAGES];

  for (genvar s = 0; s < uvs_pkg::DIV_STAGES; s++) begin : g_stage
    logic [uvs_pkg::CNT_W-1:0]     rem_next;
    logic [uvs_pkg::DIV_NUM_W-1:0] num_next;
    logic [uvs_pkg::QUO_W-1:0]     quo_next;

    // Run this stage's share of shift-and-subtract steps
    always_comb begin
      logic [uvs_pkg::CNT_W-1:0]     r;
      logic [uvs_pkg::CNT_W:0]       r2;
      logic [uvs_pkg::DIV_NUM_W-1:0] n;
      logic [uvs_pkg::QUO_W-1:0]     q;
      if (s == 0) begin
        r = '0;
        n = uvs_pkg::DIV_NUM_W'({index, {(uvs_pkg::QUO_W-1){1'b0}}});
        q = '0;
      end else begin
        r = rem_r[(s == 0) ? 0 : s-1];
        n = num_r[(s == 0) ? 0 : s-1];
        q = quo_r[(s == 0) ? 0 : s-1];
      end
      for (int k = 0; k < uvs_pkg::DIV_STEPS; k++) begin
        r2 = {r, n[uvs_pkg::DIV_NUM_W-1]};
        n  = {n[uvs_pkg::DIV_NUM_W-2:0], 1'b0};
        if (r2 >= {1'b0, count}) begin
          r2 = r2 - {1'b0, count};
          q  = {q[uvs_pkg::QUO_W-2:0], 1'b1};
        end else begin
          q  = {q[uvs_pkg::QUO_W-2:0], 1'b0};
        end
        r = r2[uvs_pkg::CNT_W-1:0];
      end
      rem_next = r;
      num_next = n;
      quo_next = q;
    end

    // Advance when the stage may move
    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_r[s] <= rem_next;
        num_r[s] <= num_next;
        quo_r[s] <= quo_next;
      end
    end
  end

  assign quo = quo_r[uvs_pkg::DIV_STAGES-1];

endmodule

// ===== hdl/uvs_sine.sv =====
// Four-stage fixed-point sine of a Q0.16 phase, result as Q1.14 magnitude and sign.
// Depends on uvs_pkg; stage enables come from the top-level pipeline control.
module uvs_sine (
  input  logic                             clk,
  input  logic [uvs_pkg::SIN_STAGES-1:0]   en,
  input  logic [15:0]                      phase,
  output uvs_pkg::sine_t                   result
);

  logic [uvs_pkg::MAG_W-1:0] xa, x2a, xb, x2b, xc, uc;
  logic [13:0]               tb;
  logic                      nega, negb, negc;
  logic [uvs_pkg::MAG_W-1:0] x_red;
  logic [29:0]               sq;
  logic [24:0]               p1;
  logic [13:0]               t_next;
  logic [28:0]               p2;
  logic [uvs_pkg::MAG_W-1:0] u_next;
  logic [29:0]               p3;

  // Reduce to a quarter wave and square
  always_comb begin
    x_red = {1'b0, phase[13:0]};
    if (phase[14]) x_red = uvs_pkg::ONE_Q14 - x_red;
    sq = 30'(x_red) * 30'(x_red);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      xa   <= x_red;
      x2a  <= sq[28:14];
      nega <= phase[15];
    end
  end

  // Inner polynomial term
  assign p1     = 25'(x2a) * 25'(uvs_pkg::SIN_C1);
  assign t_next = uvs_pkg::SIN_C2 - {3'b0, p1[24:14]};

  always_ff @(posedge clk) begin
    if (en[1]) begin
      xb   <= xa;
      x2b  <= x2a;
      tb   <= t_next;
      negb <= nega;
    end
  end

  // Middle polynomial term
  assign p2     = 29'(x2b) * 29'(tb);
  assign u_next = uvs_pkg::SIN_C3 - {1'b0, p2[27:14]};

  always_ff @(posedge clk) begin
    if (en[2]) begin
      xc   <= xb;
      uc   <= u_next;
      negc <= negb;
    end
  end

  // Final product and sign
  assign p3 = 30'(xc) * 30'(uc);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      result.mag <= p3[28:14];
      result.neg <= negc;
    end
  end

endmodule

// ===== hdl/uvs_scale.sv =====
// Two-stage scaling of sines and cosines into position and normal.
// Depends on uvs_pkg; stage enables come from the top-level pipeline control.
module uvs_scale (
  input  logic                             clk,
  input  logic [uvs_pkg::SCL_STAGES-1:0]   en,
  input  logic [uvs_pkg::RAD_W-1:0]        radius,
  input  uvs_pkg::sine_t                   si,
  input  uvs_pkg::sine_t                   ci,
  input  uvs_pkg::sine_t                   sj,
  input  uvs_pkg::sine_t                   cj,
  output uvs_pkg::vert_t                   vert
);

  logic [30:0] xz_p, y_p;
  logic [29:0] nx_p, nz_p;
  logic [15:0] xz_mag, y_mag;
  logic [14:0] nx_mag, nz_mag;
  logic        xz_neg, y_neg, nx_neg, nz_neg;
  uvs_pkg::sine_t ci_r, sj_r, cj_r;
  logic [30:0] x_p, z_p;

  // Radius and stack terms
  assign xz_p = 31'(radius) * 31'(si.mag);
  assign y_p  = 31'(radius) * 31'(ci.mag);
  assign nx_p = 30'(si.mag) * 30'(cj.mag);
  assign nz_p = 30'(si.mag) * 30'(sj.mag);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      xz_mag <= xz_p[29:14];
      xz_neg <= si.neg;
      y_mag  <= y_p[29:14];
      y_neg  <= ci.neg;
      nx_mag <= nx_p[28:14];
      nx_neg <= si.neg ^ cj.neg;
      nz_mag <= nz_p[28:14];
      nz_neg <= si.neg ^ sj.neg;
      ci_r   <= ci;
      sj_r   <= sj;
      cj_r   <= cj;
    end
  end

  // Sector terms, then apply signs
  assign x_p = 31'(xz_mag) * 31'(cj_r.mag);
  assign z_p = 31'(xz_mag) * 31'(sj_r.mag);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      vert.pos_x  <= (xz_neg ^ cj_r.neg) ? 17'sd0 - $signed({1'b0, x_p[29:14]})
                                         : $signed({1'b0, x_p[29:14]});
      vert.pos_z  <= (xz_neg ^ sj_r.neg) ? 17'sd0 - $signed({1'b0, z_p[29:14]})
                                         : $signed({1'b0, z_p[29:14]});
      vert.pos_y  <= y_neg ? 17'sd0 - $signed({1'b0, y_mag}) : $signed({1'b0, y_mag});
      vert.norm_x <= nx_neg ? 16'sd0 - $signed({1'b0, nx_mag}) : $signed({1'b0, nx_mag});
      vert.norm_z <= nz_neg ? 16'sd0 - $signed({1'b0, nz_mag}) : $signed({1'b0, nz_mag});
      vert.norm_y <= ci_r.neg ? 16'sd0 - $signed({1'b0, ci_r.mag})
                              : $signed({1'b0, ci_r.mag});
    end
  end

endmodule
